/* sv/sahp_pkg.sv */
package sahp_pkg;

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic REG_TYPE_MASK  = 1'b0;
    localparam logic REG_NAME_LIMIT = 1'b1;

    localparam logic [7:0] TYPE_MASK_RST  = 8'd15;
    localparam logic [8:0] NAME_LIMIT_RST = 9'd256;

    localparam logic [7:0] ATYP_IPV4 = 8'd1;
    localparam logic [7:0] ATYP_NAME = 8'd3;
    localparam logic [7:0] ATYP_IPV6 = 8'd4;

    localparam logic [8:0] IDX_MAX      = 9'd511;
    localparam logic [8:0] IPV4_ADDR_END = 9'd4;
    localparam logic [8:0] IPV4_PORT_END = 9'd6;
    localparam logic [8:0] IPV6_ADDR_END = 9'd16;
    localparam logic [8:0] IPV6_PORT_END = 9'd18;
    localparam logic [8:0] IDX_NAME_LEN  = 9'd1;
    localparam logic [8:0] IPV4_HDR_LEN  = 9'd7;
    localparam logic [8:0] IPV6_HDR_LEN  = 9'd19;
    localparam logic [8:0] NAME_HDR_EXTRA = 9'd4;
    localparam logic [9:0] NAME_PORT_OFS  = 10'd2;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_IPV4 = 2'd1,
        KIND_NAME = 2'd2,
        KIND_IPV6 = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SHORT = 2'd1,
        ST_LONG  = 2'd2,
        ST_TYPE  = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        status_t     status;
        kind_t       addr_kind;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [7:0]  name_length;
        logic [15:0] port_number;
        logic [8:0]  header_length;
    } out_beat_t;

    typedef struct packed {
        logic [7:0] type_mask;
        logic [8:0] name_limit;
    } cfg_t;

endpackage

/* sv/sahp_regs.sv */
module sahp_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sahp_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [sahp_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [sahp_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output sahp_pkg::cfg_t                      cfg
);
    import sahp_pkg::*;

    logic [7:0] type_mask_reg;
    logic [8:0] name_limit_reg;
    logic       wr_en;
    logic       reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            type_mask_reg  <= TYPE_MASK_RST;
            name_limit_reg <= NAME_LIMIT_RST;
        end else if (wr_en) begin
            case (reg_sel)
                REG_TYPE_MASK:  type_mask_reg  <= pwdata[7:0];
                REG_NAME_LIMIT: name_limit_reg <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_TYPE_MASK:  prdata = {24'd0, type_mask_reg};
            REG_NAME_LIMIT: prdata = {23'd0, name_limit_reg};
            default:        prdata = '0;
        endcase
    end

    assign cfg.type_mask  = type_mask_reg;
    assign cfg.name_limit = name_limit_reg;

endmodule

/* sv/sahp_parser.sv */
module sahp_parser (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sahp_pkg::cfg_t        cfg,
    input  logic                  in_valid,
    input  sahp_pkg::in_beat_t    in_beat,
    output logic                  in_take,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sahp_pkg::out_beat_t   m_beat
);
    import sahp_pkg::*;

    logic [8:0]  idx_reg,        idx_next;
    kind_t       kind_reg,       kind_next;
    logic [63:0] addr_hi_reg,    addr_hi_next;
    logic [63:0] addr_lo_reg,    addr_lo_next;
    logic [7:0]  dlen_reg,       dlen_next;
    logic [15:0] port_reg,       port_next;
    logic        given_reg,      given_next;
    logic        out_valid_reg;
    out_beat_t   out_beat_reg;

    logic        emit;
    logic        ok;
    logic [8:0]  hdr_len;
    logic [7:0]  atyp;
    logic [9:0]  port_at;
    out_beat_t   res;
    logic [7:0]  b;

    assign b       = in_beat.data_byte;
    assign in_take = in_valid && (!out_valid_reg || m_ready);
    assign atyp    = b & cfg.type_mask;
    assign port_at = {2'd0, dlen_reg} + NAME_PORT_OFS;

    always_comb begin
        idx_next      = idx_reg;
        kind_next     = kind_reg;
        addr_hi_next  = addr_hi_reg;
        addr_lo_next  = addr_lo_reg;
        dlen_next     = dlen_reg;
        port_next     = port_reg;
        given_next    = given_reg;
        emit          = 1'b0;
        ok            = 1'b0;
        hdr_len       = '0;
        res           = '0;

        if (!given_reg) begin
            if (idx_reg == '0) begin
                case (atyp)
                    ATYP_IPV4: kind_next = KIND_IPV4;
                    ATYP_NAME: kind_next = KIND_NAME;
                    ATYP_IPV6: kind_next = KIND_IPV6;
                    default: begin
                        emit       = 1'b1;
                        res.status = ST_TYPE;
                    end
                endcase
            end else begin
                case (kind_reg)
                    KIND_IPV4: begin
                        if (idx_reg <= IPV4_ADDR_END) begin
                            addr_hi_next = {addr_hi_reg[55:0], addr_lo_reg[63:56]};
                            addr_lo_next = {addr_lo_reg[55:0], b};
                        end else if (idx_reg <= IPV4_PORT_END) begin
                            port_next = {port_reg[7:0], b};
                        end
                        if (idx_reg == IPV4_PORT_END) begin
                            emit    = 1'b1;
                            ok      = 1'b1;
                            hdr_len = IPV4_HDR_LEN;
                        end
                    end
                    KIND_IPV6: begin
                        if (idx_reg <= IPV6_ADDR_END) begin
                            addr_hi_next = {addr_hi_reg[55:0], addr_lo_reg[63:56]};
                            addr_lo_next = {addr_lo_reg[55:0], b};
                        end else if (idx_reg <= IPV6_PORT_END) begin
                            port_next = {port_reg[7:0], b};
                        end
                        if (idx_reg == IPV6_PORT_END) begin
                            emit    = 1'b1;
                            ok      = 1'b1;
                            hdr_len = IPV6_HDR_LEN;
                        end
                    end
                    KIND_NAME: begin
                        if (idx_reg == IDX_NAME_LEN) begin
                            dlen_next = b;
                            if ({1'b0, b} >= cfg.name_limit) begin
                                emit       = 1'b1;
                                res.status = ST_LONG;
                            end
                        end else begin
                            if ({1'b0, idx_reg} == port_at ||
                                {1'b0, idx_reg} == port_at + 10'd1) begin
                                port_next = {port_reg[7:0], b};
                            end
                            if ({1'b0, idx_reg} == port_at + 10'd1) begin
                                emit    = 1'b1;
                                ok      = 1'b1;
                                hdr_len = {1'b0, dlen_reg} + NAME_HDR_EXTRA;
                            end
                        end
                    end
                    default: ;
                endcase
            end

            if (idx_reg != IDX_MAX) begin
                idx_next = idx_reg + 9'd1;
            end
            given_next = emit;

            if (ok) begin
                res.status        = ST_OK;
                res.addr_kind     = kind_reg;
                res.addr_high     = (kind_reg == KIND_IPV6) ? addr_hi_next : 64'd0;
                res.addr_low      = (kind_reg == KIND_NAME) ? 64'd0 : addr_lo_next;
                res.name_length   = (kind_reg == KIND_NAME) ? dlen_reg : 8'd0;
                res.port_number   = port_next;
                res.header_length = hdr_len;
            end

            if (in_beat.last_byte && !emit) begin
                emit       = 1'b1;
                res        = '0;
                res.status = ST_SHORT;
            end
        end

        if (in_beat.last_byte) begin
            idx_next      = '0;
            kind_next     = KIND_NONE;
            addr_hi_next  = '0;
            addr_lo_next  = '0;
            dlen_next     = '0;
            port_next     = '0;
            given_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= '0;
            kind_reg      <= KIND_NONE;
            addr_hi_reg   <= '0;
            addr_lo_reg   <= '0;
            dlen_reg      <= '0;
            port_reg      <= '0;
            given_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_take) begin
                idx_reg      <= idx_next;
                kind_reg     <= kind_next;
                addr_hi_reg  <= addr_hi_next;
                addr_lo_reg  <= addr_lo_next;
                dlen_reg     <= dlen_next;
                port_reg     <= port_next;
                given_reg    <= given_next;
            end
            if (in_take && emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take && emit) begin
            out_beat_reg <= res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_beat  = out_beat_reg;

    a_err_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_beat_reg.status != ST_OK) |->
            (out_beat_reg.header_length == '0 && out_beat_reg.addr_kind == KIND_NONE))
        else $error("Error result carries nonzero fields.");

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_take && in_beat.last_byte) |=> (idx_reg == '0 && !given_reg))
        else $error("Packet state not cleared after the last beat.");

    a_result_from_take: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(in_take))
        else $error("Result appeared without an input beat being processed.");

    a_ipv4_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_beat_reg.status == ST_OK &&
         out_beat_reg.addr_kind == KIND_IPV4) |->
            (out_beat_reg.header_length == IPV4_HDR_LEN &&
             out_beat_reg.addr_high == '0))
        else $error("IPv4 result has wrong header length or upper address.");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> (out_valid_reg && $stable(out_beat_reg)))
        else $error("Stalled result changed.");

endmodule

/* sv/socks_address_header_parser_core.sv */
// Parses the address header at the start of a packet that arrives one byte per beat.
// Input channel s_valid/s_ready/s_beat carries one packet byte and a last-byte flag.
// The first byte is the address type, masked by the type_mask register, followed by
// an IPv4 address, a length-prefixed domain name or an IPv6 address, and a two-byte
// big-endian port. One result beat is sent on m_valid/m_ready/m_beat per packet, for
// the byte that completes or fails the header, or for the last byte of a short packet.
// Bytes after the result up to the end of the packet produce no output.
// An accepted byte lands in the input register and is parsed from there; its result
// is registered in the result register and shown on m_beat.
// The block accepts one byte every cycle while no result is stalled at the output.
// When the receiver stalls, the result register holds its beat and no byte is parsed;
// an empty input register takes one more byte, then s_ready is low until it is taken.
// The APB port holds type_mask at address 0 and name_limit at address 4; write them
// only while no packet is in flight.
// Synchronous reset clears all packet state and both valid flags, and restores
// type_mask to 15 and name_limit to 256.
module socks_address_header_parser_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sahp_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [sahp_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [sahp_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  sahp_pkg::in_beat_t                  s_beat,
    output logic                                m_valid,
    input  logic                                m_ready,
    output sahp_pkg::out_beat_t                 m_beat
);
    import sahp_pkg::*;

    cfg_t     cfg;
    logic     in_valid_reg;
    in_beat_t in_beat_reg;
    logic     in_take;

    sahp_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign s_ready = !in_valid_reg || in_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_beat_reg <= s_beat;
        end
    end

    sahp_parser u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .in_valid (in_valid_reg),
        .in_beat  (in_beat_reg),
        .in_take  (in_take),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_beat   (m_beat)
    );

endmodule
